@@ rtl/core/gpc_pkg.sv @@
// Shared types and constants for the Goldbach pair counter.
// No dependencies.
package gpc_pkg;

	localparam int TARGET_W = 16;
	localparam int COUNT_W  = 15;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [2:0] {
		ST_CLR,
		ST_SQ_RD,
		ST_SQ_CHK,
		ST_MARK,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} state_t;

endpackage

@@ rtl/core/gpc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gpc_ram #(
	parameter int W     = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/goldbach_pair_counter_core.sv @@
// Goldbach pair counter top level: sieve sequencer, pair search, result register.
// Depends on gpc_pkg and gpc_ram.
//
// After reset the block clears its composite bitmap (one entry per cycle), then
// runs the sieve of Eratosthenes, one read per base and one write per marked
// multiple; in_ready stays low until that finishes. Each target beat then returns
// one pair_count beat: the number of odd primes p, 3 <= p <= target/2, with
// target-p also prime. An even target of 6 or more is searched at one odd
// candidate per cycle, set by the two copies of the bitmap that are read in
// parallel at p and target-p; other targets skip the search. A finished count
// sits in the output register while the next target is accepted.
module goldbach_pair_counter_core #(
	parameter int SIEVE_SIZE = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gpc_pkg::TARGET_W-1:0]  target,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gpc_pkg::COUNT_W-1:0]   pair_count
);

	import gpc_pkg::*;

	localparam int AW = $clog2(SIEVE_SIZE);
	localparam int IW = AW + 1;
	localparam int CW = (AW > TARGET_W) ? AW : TARGET_W;
	localparam int HW = TARGET_W - 1;
	localparam logic [IW-1:0]   SIZE_I  = IW'(SIEVE_SIZE);
	localparam logic [2*IW-1:0] SIZE_SQ = (2*IW)'(SIEVE_SIZE);
	localparam logic [CW:0]     SIZE_C  = (CW+1)'(SIEVE_SIZE);
	localparam logic [AW-1:0]   LAST_A  = AW'(SIEVE_SIZE - 1);

	state_t st_q, st_d;

	logic [AW-1:0]       clr_q;
	logic [IW-1:0]       i_q, j_q, j_next;
	logic [2*IW-1:0]     sq;
	logic                sieve_done_q;
	logic [TARGET_W-1:0] target_q;
	logic [HW-1:0]       p_q;
	logic [HW:0]         p_next;
	logic [TARGET_W-1:0] q_val;
	logic [CW:0]         p_ext, q_ext;
	logic                p_oob, q_oob, last_p;
	logic                valid_s1, oob_s1;
	logic [COUNT_W-1:0]  cnt_q;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  pair_count_q;

	logic                we;
	logic [AW-1:0]       waddr;
	logic [0:0]          wdata;
	logic [AW-1:0]       raddr_a, raddr_b;
	logic [0:0]          rd_a, rd_b;
	logic                accept, go, out_load;

	assign sq     = (2*IW)'(i_q) * (2*IW)'(i_q);
	assign j_next = j_q + i_q;
	assign p_next = {1'b0, p_q} + (HW+1)'(2);
	assign q_val  = target_q - TARGET_W'(p_q);
	assign p_ext  = (CW+1)'(p_q);
	assign q_ext  = (CW+1)'(q_val);
	assign p_oob  = p_ext >= SIZE_C;
	assign q_oob  = q_ext >= SIZE_C;
	assign last_p = p_next > {1'b0, target_q[TARGET_W-1:1]};
	assign accept = in_valid && in_ready;
	assign go     = !target[0] && (target >= TARGET_W'(6));

	gpc_ram #(.W(1), .DEPTH(SIEVE_SIZE)) u_map_a (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr_a), .rdata(rd_a)
	);

	gpc_ram #(.W(1), .DEPTH(SIEVE_SIZE)) u_map_b (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr_b), .rdata(rd_b)
	);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_CLR:    if (clr_q == LAST_A) st_d = ST_SQ_RD;
			ST_SQ_RD:  st_d = (sq >= SIZE_SQ) ? ST_IDLE : ST_SQ_CHK;
			ST_SQ_CHK: st_d = rd_a[0] ? ST_SQ_RD : ST_MARK;
			ST_MARK:   if (j_next >= SIZE_I) st_d = ST_SQ_RD;
			ST_IDLE:   if (accept) st_d = go ? ST_RUN : ST_FIN;
			ST_RUN:    if (last_p) st_d = ST_DRAIN;
			ST_DRAIN:  st_d = ST_FIN;
			ST_FIN:    if (out_load) st_d = ST_IDLE;
			default:   st_d = ST_CLR;
		endcase
	end

	always_comb begin
		we       = 1'b0;
		waddr    = clr_q;
		wdata    = 1'b0;
		raddr_a  = p_ext[AW-1:0];
		raddr_b  = q_ext[AW-1:0];
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (st_q)
			ST_CLR: begin
				we    = 1'b1;
				wdata = (clr_q < AW'(2)) ? 1'b1 : 1'b0;
			end
			ST_SQ_RD: raddr_a = i_q[AW-1:0];
			ST_MARK: begin
				we    = 1'b1;
				waddr = j_q[AW-1:0];
				wdata = 1'b1;
			end
			ST_IDLE: in_ready = 1'b1;
			ST_FIN:  out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_CLR;
			clr_q        <= '0;
			i_q          <= IW'(2);
			sieve_done_q <= 1'b0;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			st_q     <= st_d;
			valid_s1 <= (st_q == ST_RUN);
			if (st_q == ST_CLR) clr_q <= clr_q + AW'(1);
			if (st_q == ST_SQ_RD && sq >= SIZE_SQ) sieve_done_q <= 1'b1;
			if ((st_q == ST_SQ_CHK && rd_a[0]) || (st_q == ST_MARK && j_next >= SIZE_I)) begin
				i_q <= i_q + IW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		oob_s1 <= p_oob || q_oob;
		if (st_q == ST_SQ_CHK) j_q <= sq[IW-1:0];
		else if (st_q == ST_MARK) j_q <= j_next;
		if (accept) begin
			target_q <= target;
			p_q      <= HW'(3);
			cnt_q    <= '0;
		end else begin
			if (st_q == ST_RUN) p_q <= p_next[HW-1:0];
			if (valid_s1 && !oob_s1 && !rd_a[0] && !rd_b[0] && cnt_q != COUNT_MAX) begin
				cnt_q <= cnt_q + COUNT_W'(1);
			end
		end
		if (out_load) pair_count_q <= cnt_q;
	end

	assign out_valid  = out_valid_q;
	assign pair_count = pair_count_q;

`ifndef SYNTHESIS
	a_no_write_after_sieve: assert property (@(posedge clk) disable iff (!arst_n)
		sieve_done_q |-> !we) else $error("bitmap written after sieve finished");
	a_ready_needs_sieve: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> sieve_done_q) else $error("input ready before sieve finished");
	a_s1_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (st_q == ST_RUN || st_q == ST_DRAIN))
		else $error("lookup pending outside search");
	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FIN |-> !valid_s1) else $error("result taken before pipeline drained");
	a_run_enters_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN && last_p) |=> st_q == ST_DRAIN)
		else $error("search did not end after last candidate");
`endif

endmodule

@@ tb/goldbach_pair_counter_core_tb.sv @@
// Testbench for goldbach_pair_counter_core: a directed table, then random targets,
// each count checked against the table's value or a local sieve-based pair counter.
// Depends on gpc_pkg and the goldbach_pair_counter_core RTL.
module goldbach_pair_counter_core_tb;
	import gpc_pkg::*;

	localparam int SIEVE_SIZE = 65536;
	localparam int NUM_RANDOM = 76;
	localparam int NUM_ROWS = 24;
	localparam int NO_WANT = -1;

	typedef struct packed {
		logic [TARGET_W-1:0] value;
		int                  want;
	} row_t;

	typedef struct packed {
		logic [TARGET_W-1:0] value;
		logic [COUNT_W-1:0]  count;
	} due_t;

	// want is the count where it is obvious, NO_WANT where the predictor decides
	localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{16'd0, 0}, '{16'd1, 0}, '{16'd2, 0}, '{16'd3, 0},
		'{16'd4, 0}, '{16'd5, 0}, '{16'd6, 1}, '{16'd7, 0},
		'{16'd8, 1}, '{16'd10, 2}, '{16'd12, 1}, '{16'd14, 2},
		'{16'd16, 2}, '{16'd100, NO_WANT}, '{16'd1000, NO_WANT},
		'{16'd32767, 0}, '{16'd65535, 0}, '{16'd65533, 0},
		'{16'd65534, NO_WANT}, '{16'd65532, NO_WANT}, '{16'd32768, NO_WANT},
		'{16'd30030, NO_WANT}, '{16'd21846, NO_WANT}, '{16'd43690, NO_WANT}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [TARGET_W-1:0] target = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [COUNT_W-1:0]  pair_count;

	bit   composite [SIEVE_SIZE];
	due_t counts_due [$];
	bit   steady = 1'b0;
	int   faults = 0;
	int   beats_in = 0;
	int   beats_out = 0;
	int   nonzero_counts = 0;
	int   high_targets = 0;
	int   trivial_targets = 0;

	goldbach_pair_counter_core #(
		.SIEVE_SIZE(SIEVE_SIZE)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.target    (target),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pair_count(pair_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void mark_composites();
		for (int n = 0; n < SIEVE_SIZE; n++)
			composite[n] = 1'b0;
		composite[0] = 1'b1;
		composite[1] = 1'b1;
		for (int b = 2; b * b < SIEVE_SIZE; b++)
			if (!composite[b])
				for (int m = b * b; m < SIEVE_SIZE; m += b)
					composite[m] = 1'b1;
	endfunction

	function automatic bit is_prime(input int n);
		if (n >= SIEVE_SIZE)
			return 1'b0;
		return !composite[n];
	endfunction

	function automatic logic [COUNT_W-1:0] goldbach_pairs(input logic [TARGET_W-1:0] value);
		int n;
		int pairs;
		n = int'(value);
		pairs = 0;
		if (n % 2 == 0 && n >= 4)
			for (int p = 3; p <= n / 2; p += 2)
				if (is_prime(p) && is_prime(n - p) && pairs < int'(COUNT_MAX))
					pairs++;
		return COUNT_W'(pairs);
	endfunction

	task automatic send_target(input logic [TARGET_W-1:0] value, input int want);
		due_t entry;
		if (!steady && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		target <= value;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		entry.value = value;
		entry.count = (want == NO_WANT) ? goldbach_pairs(value) : COUNT_W'(want);
		counts_due.push_back(entry);
		@(posedge clk);
		beats_in++;
		if (value >= 16'd32768)
			high_targets++;
		if (value[0] || value < 16'd4)
			trivial_targets++;
	endtask

	task automatic drain_counts();
		in_valid <= 1'b0;
		while (counts_due.size() != 0) @(posedge clk);
	endtask

	// a beat seen at the falling edge is taken at the next rising edge
	always @(negedge clk) begin
		due_t entry;
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (pair_count != '0)
				nonzero_counts++;
			if (counts_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected pair_count beat: %0d", pair_count);
			end else begin
				entry = counts_due.pop_front();
				if (pair_count !== entry.count) begin
					faults++;
					if (faults <= 10)
						$display("target %0d: pair_count expected %0d, got %0d",
							entry.value, entry.count, pair_count);
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			if (!steady && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	end

	initial begin
		logic [TARGET_W-1:0] value;
		int pick;
		mark_composites();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++)
			send_target(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].want);
		drain_counts();

		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == NUM_RANDOM / 2)
				drain_counts();
			if (i == NUM_RANDOM - 20)
				steady = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 8)
				value = TARGET_W'($urandom);
			else if (pick < 20)
				value = TARGET_W'($urandom_range(0, 16383));
			else
				value = TARGET_W'($urandom_range(0, 2047));
			if ($urandom_range(0, 9) != 0)
				value[0] = 1'b0;
			send_target(value, NO_WANT);
		end

		drain_counts();
		repeat (16) @(posedge clk);
		if (counts_due.size() != 0) begin
			faults++;
			$display("%0d pair_count beats never arrived", counts_due.size());
		end
		$display("%0d targets sent (%0d from the table), %0d counts returned, %0d nonzero",
			beats_in, NUM_ROWS, beats_out, nonzero_counts);
		$display("%0d targets at 32768 or above, %0d odd or below 4",
			high_targets, trivial_targets);
		if (faults == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d failures", faults);
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("timeout: %0d targets sent, %0d counts returned", beats_in, beats_out);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
